// File: rtl/pgof_pkg.sv
// ----------------------------------------------------------------------------
// Pre-emphasis, gate and one-pole filter: shared package
// Widths, fixed-point constants, register codes, interface structs and the
// rounding and saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package pgof_pkg;

  // Sample and coefficient formats
  localparam int SAMPLE_BITS     = 16;
  localparam int COEFF_FRAC_BITS = 15;

  localparam int COEFF_W = COEFF_FRAC_BITS + 1;    // unsigned, may hold 1.0
  localparam int OPND_W  = SAMPLE_BITS + 1;        // difference of two samples
  localparam int ACC_W   = OPND_W + COEFF_W + 2;   // sum of two products
  localparam int QOUT_W  = ACC_W - COEFF_FRAC_BITS;
  localparam int CNT_W   = $clog2(COEFF_W + 1);
  localparam int THR_W   = SAMPLE_BITS - 1;
  localparam int FB_W    = COEFF_FRAC_BITS;

  localparam int ONE_Q        = 1 << COEFF_FRAC_BITS;
  localparam int SMOOTH_NEW_I = (ONE_Q * 2 + 5) / 10;
  localparam int ALPHA_RST_I  = (ONE_Q * 95 + 50) / 100;

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;
  typedef logic signed [OPND_W-1:0]      opnd_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic        [COEFF_W-1:0]     coef_t;

  localparam coef_t SMOOTH_NEW = coef_t'(SMOOTH_NEW_I);
  localparam coef_t SMOOTH_OLD = coef_t'(ONE_Q - SMOOTH_NEW_I);
  localparam coef_t ALPHA_RST  = coef_t'(ALPHA_RST_I);
  localparam coef_t GAIN_RST   = coef_t'(ONE_Q);
  localparam acc_t  ROUND_HALF = acc_t'(1) <<< (COEFF_FRAC_BITS - 1);

  localparam samp_t SAMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam samp_t SAMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEFF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREEMPH_EN  = 3'd0,
    REG_PREEMPH_ALP = 3'd1,
    REG_GATE_EN     = 3'd2,
    REG_GATE_THR    = 3'd3,
    REG_FILT_MODE   = 3'd4,
    REG_COEFF_GAIN  = 3'd5,
    REG_COEFF_FB    = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FILT_OFF = 2'd0,
    FILT_LP  = 2'd1,
    FILT_HP  = 2'd2,
    FILT_HPS = 2'd3
  } filt_mode_e;

  typedef struct packed {
    logic              preemph_en;
    coef_t             alpha;
    logic              gate_en;
    logic [THR_W-1:0]  gate_thr;
    filt_mode_e        mode;
    coef_t             gain;
    logic [FB_W-1:0]   feedback;
  } pgof_cfg_t;

  // Request to the serial multiply-accumulate unit:
  // result = acc_init + c0 * m0 + c1 * m1, then rounded and saturated.
  typedef struct packed {
    logic  start;
    acc_t  acc_init;
    coef_t c0;
    opnd_t m0;
    coef_t c1;
    opnd_t m1;
  } mac_req_t;

  typedef struct packed {
    logic  done;
    samp_t result;
  } mac_rsp_t;

  function automatic opnd_t sext_op(samp_t s);
    return {s[SAMPLE_BITS-1], s};
  endfunction

  function automatic acc_t sext_acc(samp_t s);
    return {{(ACC_W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
  endfunction

  // Divide by 2^Q rounding half up, then saturate to the sample width.
  function automatic samp_t scale_down(acc_t a);
    acc_t              t;
    logic [QOUT_W-1:0] q;
    samp_t             r;
    t = a + ROUND_HALF;
    q = t[ACC_W-1:COEFF_FRAC_BITS];
    if ((&q[QOUT_W-1:SAMPLE_BITS-1]) || !(|q[QOUT_W-1:SAMPLE_BITS-1])) begin
      r = q[SAMPLE_BITS-1:0];
    end else if (q[QOUT_W-1]) begin
      r = SAMP_MIN;
    end else begin
      r = SAMP_MAX;
    end
    return r;
  endfunction

endpackage

// File: rtl/pgof_in_if.sv
// ----------------------------------------------------------------------------
// Input sample channel
// Valid/ready channel carrying a raw sample and its frame start flag.
// ----------------------------------------------------------------------------
interface pgof_in_if
  import pgof_pkg::*;
;
  logic  valid;
  logic  ready;
  samp_t sample;
  logic  frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

// File: rtl/pgof_out_if.sv
// ----------------------------------------------------------------------------
// Output sample channel
// Valid/ready channel carrying one conditioned sample per transfer.
// ----------------------------------------------------------------------------
interface pgof_out_if
  import pgof_pkg::*;
;
  logic  valid;
  logic  ready;
  samp_t filtered_sample;

  modport source (output valid, output filtered_sample, input ready);
  modport sink   (input valid, input filtered_sample, output ready);
endinterface

// File: rtl/pgof_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pgof_cfg_if
  import pgof_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/pgof_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the seven control registers and flags writes to the filter
// registers so that the filter state can be cleared.
// ----------------------------------------------------------------------------
module pgof_cfg_regs
  import pgof_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  pgof_cfg_if.sink         cfg_i,
  output pgof_cfg_t        cfg_o,
  output logic             filt_clr_o
);

  pgof_cfg_t cfg_q, cfg_d;
  logic      filt_clr_d;
  logic      wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;

  always_comb begin
    cfg_d      = cfg_q;
    filt_clr_d = 1'b0;
    if (wr) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_PREEMPH_EN:  cfg_d.preemph_en = cfg_i.data[0];
        REG_PREEMPH_ALP: cfg_d.alpha      = cfg_i.data[COEFF_W-1:0];
        REG_GATE_EN:     cfg_d.gate_en    = cfg_i.data[0];
        REG_GATE_THR:    cfg_d.gate_thr   = cfg_i.data[THR_W-1:0];
        REG_FILT_MODE: begin
          cfg_d.mode = filt_mode_e'(cfg_i.data[1:0]);
          filt_clr_d = 1'b1;
        end
        REG_COEFF_GAIN: begin
          cfg_d.gain = cfg_i.data[COEFF_W-1:0];
          filt_clr_d = 1'b1;
        end
        REG_COEFF_FB: begin
          cfg_d.feedback = cfg_i.data[FB_W-1:0];
          filt_clr_d     = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preemph_en <= 1'b0;
      cfg_q.alpha      <= ALPHA_RST;
      cfg_q.gate_en    <= 1'b0;
      cfg_q.gate_thr   <= '0;
      cfg_q.mode       <= FILT_OFF;
      cfg_q.gain       <= GAIN_RST;
      cfg_q.feedback   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o      = cfg_q;
  assign filt_clr_o = filt_clr_d;

endmodule

// File: rtl/pgof_mac.sv
// ----------------------------------------------------------------------------
// Serial multiply-accumulate unit
// Forms acc_init + c0*m0 + c1*m1 one coefficient bit per cycle, then
// rounds by 2^Q and saturates the result to the sample width.
// ----------------------------------------------------------------------------
module pgof_mac
  import pgof_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_req_t req_i,
  output mac_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  acc_t             acc_q, acc_d;
  acc_t             m0_q, m0_d;
  acc_t             m1_q, m1_d;
  coef_t            c0_q, c0_d;
  coef_t            c1_q, c1_d;
  acc_t             pp0, pp1;

  // Partial products for the current coefficient bit.
  assign pp0 = c0_q[0] ? m0_q : '0;
  assign pp1 = c1_q[0] ? m1_q : '0;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    m0_d   = m0_q;
    m1_d   = m1_q;
    c0_d   = c0_q;
    c1_d   = c1_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(COEFF_W);
      acc_d  = req_i.acc_init;
      m0_d   = {{(ACC_W-OPND_W){req_i.m0[OPND_W-1]}}, req_i.m0};
      m1_d   = {{(ACC_W-OPND_W){req_i.m1[OPND_W-1]}}, req_i.m1};
      c0_d   = req_i.c0;
      c1_d   = req_i.c1;
    end else if (busy_q) begin
      acc_d = acc_q + pp0 + pp1;
      m0_d  = m0_q <<< 1;
      m1_d  = m1_q <<< 1;
      c0_d  = c0_q >> 1;
      c1_d  = c1_q >> 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      m0_q   <= '0;
      m1_q   <= '0;
      c0_q   <= '0;
      c1_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      m0_q   <= m0_d;
      m1_q   <= m1_d;
      c0_q   <= c0_d;
      c1_q   <= c1_d;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = scale_down(acc_q);

endmodule

// File: rtl/preemphasis_gate_onepole_filter_top.sv
// ----------------------------------------------------------------------------
// Pre-emphasis, noise gate and one-pole filter: top level
// Conditions one signed sample at a time through pre-emphasis, a noise
// gate and a one-pole lowpass or highpass filter with optional smoother.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on in_i (sample, frame_start) and leave on out_o, one
// result for each input transfer. Registers are written on cfg_i, which is
// always ready; write only while the block holds no sample in flight.
// Writing the mode, gain or feedback register clears the filter state.
// Each enabled stage that multiplies uses the serial multiply-accumulate
// unit, which takes one coefficient bit per cycle. A new sample is taken
// in the cycle after the previous result has been moved to the output
// register. If the receiver stalls, the finished result waits in the
// output register while the next sample is processed; that next sample
// then waits in the block until the output register is free.
// After reset all registers take their default values and the filter,
// smoother and pre-emphasis history are zero.
// ----------------------------------------------------------------------------
module preemphasis_gate_onepole_filter_top
  import pgof_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pgof_in_if.sink    in_i,
  pgof_out_if.source out_o,
  pgof_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_GATE,
    ST_FILT,
    ST_SMOOTH,
    ST_OUT
  } state_e;

  pgof_cfg_t cfg;
  logic      filt_clr;
  mac_req_t  mac_req;
  mac_rsp_t  mac_rsp;

  state_e state_q, state_d;
  samp_t  x_q, x_d;
  samp_t  v_q, v_d;
  samp_t  prev_q, prev_d;
  samp_t  s0_q, s0_d;
  samp_t  s1_q, s1_d;
  samp_t  sm_q, sm_d;
  logic   out_valid_q, out_valid_d;
  samp_t  out_data_q, out_data_d;

  logic              in_fire;
  logic [OPND_W-1:0] mag;
  samp_t             v_gated;

  pgof_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .cfg_o      (cfg),
    .filt_clr_o (filt_clr)
  );

  pgof_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  assign in_i.ready      = (state_q == ST_IDLE);
  assign in_fire         = in_i.valid & in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.filtered_sample = out_data_q;

  // Noise gate on the stored value.
  assign mag     = v_q[SAMPLE_BITS-1] ? -sext_op(v_q) : sext_op(v_q);
  assign v_gated = (cfg.gate_en && (mag < OPND_W'(cfg.gate_thr))) ? '0 : v_q;

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    v_d         = v_q;
    prev_d      = prev_q;
    s0_d        = s0_q;
    s1_d        = s1_q;
    sm_d        = sm_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mac_req     = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          x_d = in_i.sample;
          if (in_i.frame_start) begin
            sm_d = '0;
          end
          if (cfg.preemph_en) begin
            mac_req.start    = 1'b1;
            mac_req.acc_init = sext_acc(in_i.sample) <<< COEFF_FRAC_BITS;
            mac_req.c0       = cfg.alpha;
            mac_req.m0       = -sext_op(prev_q);
            state_d          = ST_PRE;
          end else begin
            v_d     = in_i.sample;
            state_d = ST_GATE;
          end
        end
      end
      ST_PRE: begin
        if (mac_rsp.done) begin
          v_d     = mac_rsp.result;
          prev_d  = x_q;
          state_d = ST_GATE;
        end
      end
      ST_GATE: begin
        v_d = v_gated;
        if (cfg.mode == FILT_OFF) begin
          state_d = ST_OUT;
        end else begin
          mac_req.start = 1'b1;
          mac_req.c0    = cfg.gain;
          mac_req.m0    = (cfg.mode == FILT_LP) ? sext_op(v_gated)
                                                : sext_op(v_gated) - sext_op(s1_q);
          mac_req.c1    = {1'b0, cfg.feedback};
          mac_req.m1    = sext_op(s0_q);
          state_d       = ST_FILT;
        end
      end
      ST_FILT: begin
        if (mac_rsp.done) begin
          s0_d = mac_rsp.result;
          v_d  = mac_rsp.result;
          if (cfg.mode != FILT_LP) begin
            s1_d = v_q;
          end
          if (cfg.mode == FILT_HPS) begin
            mac_req.start = 1'b1;
            mac_req.c0    = SMOOTH_NEW;
            mac_req.m0    = sext_op(mac_rsp.result);
            mac_req.c1    = SMOOTH_OLD;
            mac_req.m1    = sext_op(sm_q);
            state_d       = ST_SMOOTH;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_SMOOTH: begin
        if (mac_rsp.done) begin
          sm_d    = mac_rsp.result;
          v_d     = mac_rsp.result;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = v_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (filt_clr) begin
      s0_d = '0;
      s1_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      v_q         <= '0;
      prev_q      <= '0;
      s0_q        <= '0;
      s1_q        <= '0;
      sm_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      v_q         <= v_d;
      prev_q      <= prev_d;
      s0_q        <= s0_d;
      s1_q        <= s1_d;
      sm_q        <= sm_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the pre-emphasis, noise gate and one-pole filter block
// Drives samples and register writes over valid/ready channels with random
// gaps and stalls. Every output transfer is compared with a sample-accurate
// software copy of the conditioning chain, kept in step with each write.
// ----------------------------------------------------------------------------
module tb;
  import pgof_pkg::*;

  localparam int     QUIET_LIMIT = 5000;
  localparam int     TAIL_CYCLES = 80;
  localparam longint UNITY       = longint'(1) << COEFF_FRAC_BITS;
  localparam longint HALF_LSB    = UNITY / 2;
  localparam longint OUT_HI      = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_LO      = -OUT_HI - 1;
  localparam longint W_NEW       = (UNITY * 2 + 5) / 10;
  localparam longint W_OLD       = UNITY - W_NEW;

  // Index past the end of the register map; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic clk;
  logic rst_n;

  pgof_in_if  in_if ();
  pgof_out_if out_if ();
  pgof_cfg_if cfg_if ();

  preemphasis_gate_onepole_filter_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Register copy
  logic              pe_en;
  logic [15:0]       pe_alpha;
  logic              gate_en;
  logic [THR_W-1:0]  gate_thr;
  filt_mode_e        mode_r;
  logic [15:0]       gain_r;
  logic [FB_W-1:0]   fb_r;

  // Chain state
  longint hist_sample;
  longint filt_out;
  longint filt_in;
  longint smooth_acc;

  samp_t  conditioned_q[$];
  int     outstanding;
  int     n_items;
  int     n_directed;
  int     n_checked;
  int     n_writes;
  int     n_errors;
  int     quiet_cycles;
  int     stall_left;
  bit     idle_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint round_sat(longint v);
    longint q;
    q = (v + HALF_LSB) >>> COEFF_FRAC_BITS;
    if (q > OUT_HI) q = OUT_HI;
    if (q < OUT_LO) q = OUT_LO;
    return q;
  endfunction

  function automatic void model_reset();
    pe_en       = 1'b0;
    pe_alpha    = 16'd31130;
    gate_en     = 1'b0;
    gate_thr    = '0;
    mode_r      = FILT_OFF;
    gain_r      = 16'd32768;
    fb_r        = '0;
    hist_sample = 0;
    filt_out    = 0;
    filt_in     = 0;
    smooth_acc  = 0;
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
    case (idx)
      REG_PREEMPH_EN:  pe_en    = d[0];
      REG_PREEMPH_ALP: pe_alpha = d;
      REG_GATE_EN:     gate_en  = d[0];
      REG_GATE_THR:    gate_thr = d[THR_W-1:0];
      REG_FILT_MODE:   mode_r   = filt_mode_e'(d[1:0]);
      REG_COEFF_GAIN:  gain_r   = d;
      REG_COEFF_FB:    fb_r     = d[FB_W-1:0];
      default: ;
    endcase
    if (idx == REG_FILT_MODE || idx == REG_COEFF_GAIN || idx == REG_COEFF_FB) begin
      filt_out = 0;
      filt_in  = 0;
    end
  endfunction

  function automatic samp_t condition_sample(samp_t x, logic fs);
    longint v;
    longint y;
    longint mag;
    longint a0;
    longint a1;
    a0 = longint'(gain_r);
    a1 = longint'(fb_r);
    v  = longint'(x);
    if (fs) smooth_acc = 0;
    if (pe_en) begin
      v = round_sat(longint'(x) * UNITY - longint'(pe_alpha) * hist_sample);
      hist_sample = longint'(x);
    end
    if (gate_en) begin
      mag = (v < 0) ? -v : v;
      if (mag < longint'(gate_thr)) v = 0;
    end
    case (mode_r)
      FILT_LP: begin
        filt_out = round_sat(a0 * v + a1 * filt_out);
        v = filt_out;
      end
      FILT_HP, FILT_HPS: begin
        y = round_sat(a0 * (v - filt_in) + a1 * filt_out);
        filt_in  = v;
        filt_out = y;
        v = y;
        if (mode_r == FILT_HPS) begin
          smooth_acc = round_sat(W_NEW * y + W_OLD * smooth_acc);
          v = smooth_acc;
        end
      end
      default: ;
    endcase
    return samp_t'(v);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic samp_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return SAMP_MAX;
        1:       return SAMP_MIN;
        2:       return samp_t'(0);
        default: return samp_t'(-1);
      endcase
    end
    if (r < 50) return samp_t'(int'($urandom_range(0, 4000)) - 2000);
    return samp_t'($urandom);
  endfunction

  function automatic logic [15:0] pick_word(int top);
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'(top);
      2:       return 16'hFFFF;
      3, 4, 5: return 16'($urandom_range(0, top));
      default: return 16'($urandom_range(0, top / 16));
    endcase
  endfunction

  task automatic send_sample(samp_t s, logic fs);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.frame_start <= fs;
    do @(posedge clk); while (!in_if.ready);
    conditioned_q.push_back(condition_sample(s, fs));
    outstanding++;
    n_items++;
  endtask

  // Stop sending and wait until every result has been taken.
  task automatic settle();
    in_if.valid <= 1'b0;
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    model_write(idx, d);
    n_writes++;
  endtask

  task automatic reg_close();
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_passthrough();
    send_sample(SAMP_MAX, 1'b1);
    send_sample(SAMP_MIN, 1'b0);
    send_sample(samp_t'(0), 1'b0);
    send_sample(samp_t'(-1), 1'b1);
    send_sample(samp_t'(1), 1'b0);
  endtask

  task automatic test_preemphasis();
    settle();
    reg_write(REG_PREEMPH_EN, 16'd1);
    reg_write(REG_PREEMPH_ALP, 16'd32768);
    reg_close();
    send_sample(SAMP_MAX, 1'b0);
    send_sample(SAMP_MIN, 1'b0);
    send_sample(SAMP_MAX, 1'b1);
    settle();
    reg_write(REG_PREEMPH_ALP, 16'hFFFF);
    reg_close();
    send_sample(SAMP_MIN, 1'b0);
    settle();
    // With the stage off the history must hold the last sample seen while on.
    reg_write(REG_PREEMPH_EN, 16'd0);
    reg_close();
    send_sample(samp_t'(1234), 1'b0);
    settle();
    reg_write(REG_PREEMPH_EN, 16'd1);
    reg_write(REG_PREEMPH_ALP, 16'd16384);
    reg_close();
    send_sample(samp_t'(100), 1'b0);
    settle();
    reg_write(REG_PREEMPH_EN, 16'd0);
    reg_close();
  endtask

  task automatic test_gate();
    settle();
    reg_write(REG_GATE_EN, 16'd1);
    reg_write(REG_GATE_THR, 16'd100);
    reg_close();
    send_sample(samp_t'(99), 1'b0);
    send_sample(samp_t'(-99), 1'b0);
    send_sample(samp_t'(100), 1'b0);
    send_sample(samp_t'(-100), 1'b1);
    settle();
    reg_write(REG_GATE_THR, 16'h7FFF);
    reg_close();
    send_sample(SAMP_MIN, 1'b0);
    send_sample(samp_t'(32766), 1'b0);
    settle();
    reg_write(REG_GATE_EN, 16'd0);
    reg_close();
  endtask

  task automatic test_filters();
    settle();
    reg_write(REG_FILT_MODE, CFG_DATA_W'(FILT_LP));
    reg_write(REG_COEFF_GAIN, 16'd32768);
    reg_write(REG_COEFF_FB, 16'd32767);
    reg_close();
    send_sample(SAMP_MAX, 1'b0);
    send_sample(SAMP_MAX, 1'b0);
    settle();
    reg_write(REG_FILT_MODE, CFG_DATA_W'(FILT_HP));
    reg_write(REG_COEFF_GAIN, 16'hFFFF);
    reg_write(REG_COEFF_FB, 16'd16384);
    reg_close();
    send_sample(SAMP_MIN, 1'b0);
    send_sample(SAMP_MAX, 1'b0);
    send_sample(samp_t'(0), 1'b0);
    settle();
    reg_write(REG_FILT_MODE, CFG_DATA_W'(FILT_HPS));
    reg_write(REG_COEFF_GAIN, 16'd32768);
    reg_write(REG_COEFF_FB, 16'd0);
    reg_close();
    send_sample(samp_t'(20000), 1'b1);
    send_sample(samp_t'(20000), 1'b0);
    send_sample(samp_t'(-5000), 1'b1);
  endtask

  task automatic test_random(int phases, int per_phase);
    logic [15:0] val [7];
    int          frame_left;
    logic        fs;
    bit          every_reg;
    for (int p = 0; p < phases; p++) begin
      settle();
      every_reg = (p < 2) || ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        val[REG_PREEMPH_EN]  = 16'd1;
        val[REG_PREEMPH_ALP] = 16'd32768;
        val[REG_GATE_EN]     = 16'd1;
        val[REG_GATE_THR]    = 16'd32767;
        val[REG_FILT_MODE]   = 16'(FILT_HPS);
        val[REG_COEFF_GAIN]  = 16'd32768;
        val[REG_COEFF_FB]    = 16'd32767;
      end else if (p == 1) begin
        val[REG_PREEMPH_EN]  = 16'd0;
        val[REG_PREEMPH_ALP] = 16'd0;
        val[REG_GATE_EN]     = 16'd0;
        val[REG_GATE_THR]    = 16'd0;
        val[REG_FILT_MODE]   = 16'(FILT_LP);
        val[REG_COEFF_GAIN]  = 16'd0;
        val[REG_COEFF_FB]    = 16'd0;
      end else begin
        val[REG_PREEMPH_EN]  = 16'($urandom);
        val[REG_PREEMPH_ALP] = pick_word(32768);
        val[REG_GATE_EN]     = 16'($urandom);
        val[REG_GATE_THR]    = pick_word(32767);
        val[REG_FILT_MODE]   = 16'($urandom);
        val[REG_COEFF_GAIN]  = pick_word(32768);
        val[REG_COEFF_FB]    = pick_word(32767);
      end
      // Leaving some registers untouched lets the filter state run across phases.
      for (int r = 0; r < 7; r++) begin
        if (every_reg || $urandom_range(0, 9) < 7) begin
          reg_write(CFG_IDX_W'(r), val[CFG_IDX_W'(r)]);
        end
      end
      if ($urandom_range(0, 3) == 0) reg_write(REG_SPARE, 16'($urandom));
      reg_close();
      idle_on    = (p % 5 != 3);
      frame_left = 0;
      for (int i = 0; i < per_phase; i++) begin
        if (frame_left == 0) begin
          fs         = 1'b1;
          frame_left = $urandom_range(1, 48);
        end else begin
          fs = ($urandom_range(0, 31) == 0);
        end
        frame_left--;
        send_sample(rand_sample(), fs);
        if ($urandom_range(0, 199) == 0) settle();
      end
    end
    idle_on = 1'b1;
  endtask

  // Output side: check each transfer and stall at random.
  always @(posedge clk) begin
    samp_t want;
    if (out_if.valid && out_if.ready) begin
      if (conditioned_q.size() == 0) begin
        $display("%0t: output transfer with nothing pending, got %0d",
                 $time, out_if.filtered_sample);
        n_errors++;
      end else begin
        want = conditioned_q.pop_front();
        outstanding--;
        n_checked++;
        if (out_if.filtered_sample !== want) begin
          $display("%0t: filtered_sample mismatch, expected %0d, got %0d",
                   $time, want, out_if.filtered_sample);
          n_errors++;
        end
      end
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.sample      = '0;
    in_if.frame_start = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    outstanding       = 0;
    n_items           = 0;
    n_checked         = 0;
    n_writes          = 0;
    n_errors          = 0;
    quiet_cycles      = 0;
    stall_left        = 0;
    idle_on           = 1'b1;
    model_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_preemphasis();
    test_gate();
    test_filters();
    n_directed = n_items;
    test_random(16, 125);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d samples (%0d directed) and %0d register writes.",
             n_items, n_directed, n_writes);
    $display("%0d results compared, %0d mismatches or stray results.",
             n_checked, n_errors);
    if (n_errors == 0 && conditioned_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
